@@ hw/rtl/kfr_pkg.sv @@
// Package with the shared types and constants of the K-line frame receiver.
package kfr_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [AddrW-1:0] AddrMinLength   = 4'h0;
  localparam logic [AddrW-1:0] AddrMaxLength   = 4'h4;
  localparam logic [AddrW-1:0] AddrByteTimeout = 4'h8;

  localparam logic [5:0]  MinLengthReset   = 6'd1;
  localparam logic [5:0]  MaxLengthReset   = 6'd63;
  localparam logic [15:0] ByteTimeoutReset = 16'd100;

  localparam logic [5:0] LenMask       = 6'b11_1111;
  localparam logic [6:0] FrameOverhead = 7'd4;
  localparam logic [6:0] MaxByteIndex  = 7'd66;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_CSUM     = 3'd2,
    ST_BADLEN   = 3'd3,
    ST_OVERTIME = 3'd4
  } frame_status_e;

  typedef struct packed {
    logic [7:0]    data_byte;
    logic [6:0]    byte_index;
    frame_status_e frame_status;
  } result_t;

endpackage

@@ hw/rtl/kline_frame_receiver.sv @@
// Top level of the K-line frame receiver: frame state, result register and register port.
// A result is registered and shown on the master side in the cycle after its acceptance.
// One byte or tick per cycle unless stalled; frame state is updated in the accept cycle.
// A tick that produces no result is consumed without touching the output register.
// The input is stalled only while a result waits in the output register and is not taken.
// Reset (rst_ni low, asynchronous) empties the output register, closes any open frame
// and restores min_length 1, max_length 63 and byte_timeout 100.
module kline_frame_receiver (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] rx_byte
  input  logic                      s_axis_tuser,  // [0] req_type
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,  // [7:0] data_byte, [14:8] byte_index,
                                                   // [17:15] frame_status, [23:18] zero
  output logic                      m_axis_tlast,  // frame_last
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kfr_pkg::AddrW-1:0] paddr,
  input  logic [kfr_pkg::DataW-1:0] pwdata,
  output logic [kfr_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import kfr_pkg::*;

  logic [5:0]  min_length_q;
  logic [5:0]  max_length_q;
  logic [15:0] byte_timeout_q;

  logic        in_frame_q, in_frame_d;
  logic [6:0]  frame_total_q, frame_total_d;
  logic [6:0]  next_index_q, next_index_d;
  logic [7:0]  running_sum_q, running_sum_d;
  logic [15:0] idle_ticks_q, idle_ticks_d;

  logic        out_valid_q;
  result_t     out_q, res_d;
  logic        out_last_q, last_d;
  logic        has_res;

  logic        accept;
  logic        cfg_write;
  logic [5:0]  len;
  logic        len_bad;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q   <= MinLengthReset;
      max_length_q   <= MaxLengthReset;
      byte_timeout_q <= ByteTimeoutReset;
    end else if (cfg_write) begin
      case (paddr)
        AddrMinLength:   min_length_q   <= pwdata[5:0];
        AddrMaxLength:   max_length_q   <= pwdata[5:0];
        AddrByteTimeout: byte_timeout_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      AddrMinLength:   prdata = {26'd0, min_length_q};
      AddrMaxLength:   prdata = {26'd0, max_length_q};
      AddrByteTimeout: prdata = {16'd0, byte_timeout_q};
      default:         prdata = '0;
    endcase
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign len     = s_axis_tdata[5:0] & LenMask;
  assign len_bad = (len < min_length_q) || (len > max_length_q);

  always_comb begin
    in_frame_d    = in_frame_q;
    frame_total_d = frame_total_q;
    next_index_d  = next_index_q;
    running_sum_d = running_sum_q;
    idle_ticks_d  = idle_ticks_q;
    has_res       = 1'b0;
    last_d        = 1'b0;
    res_d         = '{data_byte: s_axis_tdata, byte_index: 7'd0, frame_status: ST_BUSY};

    if (req_type_e'(s_axis_tuser) == REQ_TICK) begin
      if (in_frame_q) begin
        if (idle_ticks_q >= byte_timeout_q) begin
          has_res       = 1'b1;
          last_d        = 1'b1;
          res_d         = '{data_byte: 8'd0, byte_index: next_index_q,
                            frame_status: ST_OVERTIME};
          in_frame_d    = 1'b0;
          frame_total_d = '0;
          next_index_d  = '0;
          running_sum_d = '0;
          idle_ticks_d  = '0;
        end else begin
          idle_ticks_d = idle_ticks_q + 16'd1;
        end
      end
    end else if (!in_frame_q) begin
      has_res = 1'b1;
      if (len_bad) begin
        last_d             = 1'b1;
        res_d.frame_status = ST_BADLEN;
      end else begin
        in_frame_d    = 1'b1;
        frame_total_d = {1'b0, len} + FrameOverhead;
        next_index_d  = 7'd1;
        running_sum_d = s_axis_tdata;
        idle_ticks_d  = '0;
      end
    end else begin
      has_res          = 1'b1;
      idle_ticks_d     = '0;
      res_d.byte_index = next_index_q;
      if ({1'b0, next_index_q} + 8'd1 >= {1'b0, frame_total_q}) begin
        last_d             = 1'b1;
        res_d.frame_status = (s_axis_tdata == running_sum_q) ? ST_OK : ST_CSUM;
        in_frame_d         = 1'b0;
        frame_total_d      = '0;
        next_index_d       = '0;
        running_sum_d      = '0;
      end else begin
        running_sum_d = running_sum_q + s_axis_tdata;
        next_index_d  = next_index_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q    <= 1'b0;
      frame_total_q <= '0;
      next_index_q  <= '0;
      running_sum_q <= '0;
      idle_ticks_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        in_frame_q    <= in_frame_d;
        frame_total_q <= frame_total_d;
        next_index_q  <= next_index_d;
        running_sum_q <= running_sum_d;
        idle_ticks_q  <= idle_ticks_d;
      end
      if (accept && has_res) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && has_res) begin
      out_q      <= res_d;
      out_last_q <= last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.frame_status, out_q.byte_index, out_q.data_byte};
  assign m_axis_tlast  = out_last_q;

endmodule

@@ hw/rtl/kfr_checker.sv @@
// Port-level checker for the K-line frame receiver, with its bind statement.
module kfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import kfr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result transaction changed while stalled");

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[17:15] != ST_BUSY)))
    else $error("frame_last disagrees with frame_status");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled although the output register can take a result");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[14:8] <= MaxByteIndex)
    else $error("byte_index beyond the longest frame");

  a_badlen_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17:15] == ST_BADLEN |-> m_axis_tdata[14:8] == 7'd0)
    else $error("bad length reported on a byte other than the format byte");

endmodule

bind kline_frame_receiver kfr_checker u_kfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
